// ===== sv/lkm_pkg.sv =====
// ----------------------------------------------------------------------------
// lkm_pkg
// shared types and constants for the lamport k-slot mutual exclusion node
// ----------------------------------------------------------------------------
package lkm_pkg;

    localparam int ID_W    = 3;
    localparam int MASK_W  = 8;
    localparam int PORT_SW = 32;
    localparam int CFG_W   = 3;

    typedef enum logic [1:0] {
        OP_LOCAL_REQ = 2'd0,
        OP_LOCAL_REL = 2'd1,
        OP_IN_REQ    = 2'd2,
        OP_IN_ACK    = 2'd3
    } t_op;

    typedef enum logic {
        CFG_OWN_ID     = 1'b0,
        CFG_SLOT_COUNT = 1'b1
    } t_cfg_addr;

    typedef struct packed {
        logic [MASK_W-1:0]  ack_mask;
        logic               request_out;
        logic [PORT_SW-1:0] out_stamp;
        logic               grant;
        logic               inside_res;
    } t_result;

endpackage

// ===== sv/lamport_k_mutex_node.sv =====
// ----------------------------------------------------------------------------
// lamport_k_mutex_node
// one node of a lamport-clock mutual exclusion over shared slots
//
//   channel   direction  handshake            payload
//   event     in         i_valid / o_ready    i_op, i_src, i_stamp
//   result    out        o_valid / i_ready    o_ack_mask, o_request_out,
//                                             o_out_stamp, o_grant, o_inside_res
//   config    in         i_cfg_we             i_cfg_addr, i_cfg_data
//
// one event per cycle when not stalled; input register, then the event
// logic writes node state and the result register in the same cycle
// reset is synchronous, active low, and clears all node state and config
// a stalled result register holds the input register, which holds upstream
// ----------------------------------------------------------------------------
module lamport_k_mutex_node
    import lkm_pkg::*;
#(
    parameter int NODES      = 8,
    parameter int STAMP_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic [ID_W-1:0]    i_src,
    input  logic [PORT_SW-1:0] i_stamp,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [MASK_W-1:0]  o_ack_mask,
    output logic               o_request_out,
    output logic [PORT_SW-1:0] o_out_stamp,
    output logic               o_grant,
    output logic               o_inside_res,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    logic [ID_W-1:0]       r_own_id;
    logic [CFG_W-1:0]      r_slot_count;

    logic                  r_in_valid;
    t_op                   r_op;
    logic [ID_W-1:0]       r_src;
    logic [STAMP_BITS-1:0] r_stamp;

    logic [STAMP_BITS-1:0] r_clock,        n_clock;
    logic [STAMP_BITS-1:0] r_request_time, n_request_time;
    logic [STAMP_BITS-1:0] r_entry_time,   n_entry_time;
    logic [NODES-1:0]      r_ack_bits,     n_ack_bits;
    logic [NODES-1:0]      r_pending_bits, n_pending_bits;
    logic                  r_requesting,   n_requesting;
    logic                  r_occupied,     n_occupied;

    logic                  r_out_valid;
    t_result               r_res,          n_res;
    logic                  advance;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id     <= '0;
            r_slot_count <= CFG_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_OWN_ID:     r_own_id     <= ID_W'(i_cfg_data);
                CFG_SLOT_COUNT: r_slot_count <= i_cfg_data;
                default:        r_own_id     <= r_own_id;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op    <= t_op'(i_op);
            r_src   <= i_src;
            r_stamp <= STAMP_BITS'(i_stamp);
        end
    end

    lkm_step #(
        .NODES      (NODES),
        .STAMP_BITS (STAMP_BITS)
    ) u_step (
        .i_op           (r_op),
        .i_src          (r_src),
        .i_stamp        (r_stamp),
        .i_own_id       (r_own_id),
        .i_slot_count   (r_slot_count),
        .i_clock        (r_clock),
        .i_request_time (r_request_time),
        .i_entry_time   (r_entry_time),
        .i_ack_bits     (r_ack_bits),
        .i_pending_bits (r_pending_bits),
        .i_requesting   (r_requesting),
        .i_occupied     (r_occupied),
        .o_clock        (n_clock),
        .o_request_time (n_request_time),
        .o_entry_time   (n_entry_time),
        .o_ack_bits     (n_ack_bits),
        .o_pending_bits (n_pending_bits),
        .o_requesting   (n_requesting),
        .o_occupied     (n_occupied),
        .o_res          (n_res)
    );

    // node state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock        <= '0;
            r_request_time <= '0;
            r_entry_time   <= '0;
            r_ack_bits     <= '0;
            r_pending_bits <= '0;
            r_requesting   <= 1'b0;
            r_occupied     <= 1'b0;
        end else if (advance) begin
            r_clock        <= n_clock;
            r_request_time <= n_request_time;
            r_entry_time   <= n_entry_time;
            r_ack_bits     <= n_ack_bits;
            r_pending_bits <= n_pending_bits;
            r_requesting   <= n_requesting;
            r_occupied     <= n_occupied;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_ack_mask    = r_res.ack_mask;
    assign o_request_out = r_res.request_out;
    assign o_out_stamp   = r_res.out_stamp;
    assign o_grant       = r_res.grant;
    assign o_inside_res  = r_res.inside_res;

    a_grant_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_grant) |-> o_inside_res)
        else $error("grant without inside");

    a_req_xor_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_request_out && (o_ack_mask != '0)))
        else $error("request and acknowledge in one result");

    a_req_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_requesting && r_occupied))
        else $error("requesting while inside");

    a_clock_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_clock >= $past(r_clock)))
        else $error("lamport clock went backward");

    a_enter_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_occupied) |-> (r_ack_bits == '0))
        else $error("ack bits not cleared on entry");

endmodule

// ===== sv/lkm_step.sv =====
// ----------------------------------------------------------------------------
// lkm_step
// next-state and result logic for one event against the node state
// ----------------------------------------------------------------------------
module lkm_step
    import lkm_pkg::*;
#(
    parameter int NODES      = 8,
    parameter int STAMP_BITS = 32
) (
    input  t_op                        i_op,
    input  logic [ID_W-1:0]            i_src,
    input  logic [STAMP_BITS-1:0]      i_stamp,
    input  logic [ID_W-1:0]            i_own_id,
    input  logic [CFG_W-1:0]           i_slot_count,
    input  logic [STAMP_BITS-1:0]      i_clock,
    input  logic [STAMP_BITS-1:0]      i_request_time,
    input  logic [STAMP_BITS-1:0]      i_entry_time,
    input  logic [NODES-1:0]           i_ack_bits,
    input  logic [NODES-1:0]           i_pending_bits,
    input  logic                       i_requesting,
    input  logic                       i_occupied,
    output logic [STAMP_BITS-1:0]      o_clock,
    output logic [STAMP_BITS-1:0]      o_request_time,
    output logic [STAMP_BITS-1:0]      o_entry_time,
    output logic [NODES-1:0]           o_ack_bits,
    output logic [NODES-1:0]           o_pending_bits,
    output logic                       o_requesting,
    output logic                       o_occupied,
    output t_result                    o_res
);

    localparam int CW = $clog2(NODES + 1);

    function automatic logic [STAMP_BITS-1:0] bump(input logic [STAMP_BITS-1:0] v);
        bump = (&v) ? v : v + STAMP_BITS'(1);
    endfunction

    logic [CFG_W-1:0]      slots;
    logic [CW-1:0]         need;
    logic [CW-1:0]         ack_cnt;
    logic [NODES-1:0]      src_bit;
    logic [NODES-1:0]      acks;
    logic                  src_ok;
    logic                  wins;
    logic [STAMP_BITS-1:0] clk_max;

    always_comb begin
        slots = (i_slot_count == '0) ? CFG_W'(1) : i_slot_count;
        if (int'(slots) >= NODES) begin
            need = '0;
        end else begin
            need = CW'(NODES - int'(slots));
        end
    end

    assign src_bit = NODES'(1) << i_src;
    assign src_ok  = (i_src != i_own_id) && (32'(i_src) < NODES);
    assign clk_max = bump((i_clock > i_stamp) ? i_clock : i_stamp);
    assign wins    = !i_requesting || (i_stamp < i_request_time) ||
                     ((i_stamp == i_request_time) && (i_src < i_own_id));
    assign acks    = i_ack_bits | src_bit;

    always_comb begin
        ack_cnt = '0;
        for (int n = 0; n < NODES; n++) begin
            ack_cnt = ack_cnt + CW'(acks[n]);
        end
    end

    always_comb begin
        o_clock        = i_clock;
        o_request_time = i_request_time;
        o_entry_time   = i_entry_time;
        o_ack_bits     = i_ack_bits;
        o_pending_bits = i_pending_bits;
        o_requesting   = i_requesting;
        o_occupied     = i_occupied;
        o_res          = '0;
        case (i_op)
            OP_LOCAL_REQ: begin
                if (!i_requesting && !i_occupied) begin
                    o_clock         = bump(i_clock);
                    o_request_time  = o_clock;
                    o_ack_bits      = '0;
                    o_requesting    = 1'b1;
                    o_res.request_out = 1'b1;
                    o_res.out_stamp = PORT_SW'(o_clock);
                    // enough slots for everyone: enter at once
                    if (need == '0) begin
                        o_occupied   = 1'b1;
                        o_requesting = 1'b0;
                        o_entry_time = o_clock;
                        o_res.grant  = 1'b1;
                    end
                end
            end
            OP_LOCAL_REL: begin
                if (i_occupied) begin
                    o_occupied = 1'b0;
                    if (i_pending_bits != '0) begin
                        o_clock         = bump(i_clock);
                        o_res.ack_mask  = MASK_W'(i_pending_bits);
                        o_res.out_stamp = PORT_SW'(o_clock);
                        o_pending_bits  = '0;
                    end
                end
            end
            OP_IN_REQ: begin
                if (src_ok) begin
                    o_clock = clk_max;
                    if (!i_occupied && wins) begin
                        o_clock         = bump(clk_max);
                        o_res.ack_mask  = MASK_W'(src_bit);
                        o_res.out_stamp = PORT_SW'(o_clock);
                    end else begin
                        o_pending_bits = i_pending_bits | src_bit;
                    end
                end
            end
            OP_IN_ACK: begin
                if (src_ok) begin
                    o_clock = clk_max;
                    if (i_requesting && (i_stamp > i_request_time) &&
                        (i_stamp > i_entry_time)) begin
                        o_ack_bits = acks;
                        if (ack_cnt >= need) begin
                            o_occupied   = 1'b1;
                            o_requesting = 1'b0;
                            o_entry_time = clk_max;
                            o_ack_bits   = '0;
                            o_res.grant  = 1'b1;
                        end
                    end
                end
            end
            default: begin
                o_res = '0;
            end
        endcase
        o_res.inside_res = o_occupied;
    end

endmodule

// ===== tb/lkm_node_checker.sv =====
// ----------------------------------------------------------------------------
// lkm_node_checker
// watches the event, result and register ports of the mutual exclusion node,
// keeps its own copy of the lamport clock, request and deferral state, and
// compares every result transfer against the oldest predicted result
// ----------------------------------------------------------------------------
module lkm_node_checker
    import lkm_pkg::*;
#(
    parameter int NODES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ev_valid,
    input  logic               i_ev_ready,
    input  logic [1:0]         i_op,
    input  logic [ID_W-1:0]    i_src,
    input  logic [PORT_SW-1:0] i_stamp,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [MASK_W-1:0]  i_ack_mask,
    input  logic               i_request_out,
    input  logic [PORT_SW-1:0] i_out_stamp,
    input  logic               i_grant,
    input  logic               i_inside_res,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output int                 o_errors,
    output int                 o_waiting,
    output int                 o_grants,
    output int                 o_batches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOWN = 10;

    logic [PORT_SW-1:0] lam_clock;
    logic [PORT_SW-1:0] req_stamp;
    logic [PORT_SW-1:0] entry_stamp;
    logic [MASK_W-1:0]  acks_held;
    logic [MASK_W-1:0]  deferred;
    logic               wanting;
    logic               holding;
    logic [ID_W-1:0]    my_id;
    logic [CFG_W-1:0]   slots;
    t_result            expected_q[$];
    t_result            want;
    t_result            got;
    int                 errors = 0;
    int                 waiting = 0;
    int                 grants = 0;
    int                 batches = 0;

    assign o_errors  = errors;
    assign o_waiting = waiting;
    assign o_grants  = grants;
    assign o_batches = batches;

    function automatic logic [PORT_SW-1:0] tick(input logic [PORT_SW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic enter_if_ready();
        int k;
        int need;
        k = (slots == 0) ? 1 : int'(slots);
        need = (k >= NODES) ? 0 : NODES - k;
        if (!wanting || $countones(acks_held) < need) return 1'b0;
        holding     = 1'b1;
        wanting     = 1'b0;
        entry_stamp = lam_clock;
        acks_held   = '0;
        return 1'b1;
    endfunction

    function automatic t_result predict_event(input t_op op, input logic [ID_W-1:0] src,
                                              input logic [PORT_SW-1:0] stamp);
        t_result           r;
        logic [MASK_W-1:0] src_bit;
        logic              wins;
        r = '0;
        src_bit = MASK_W'(1) << src;
        case (op)
            OP_LOCAL_REQ: begin
                if (!wanting && !holding) begin
                    lam_clock     = tick(lam_clock);
                    req_stamp     = lam_clock;
                    acks_held     = '0;
                    wanting       = 1'b1;
                    r.request_out = 1'b1;
                    r.out_stamp   = lam_clock;
                    r.grant       = enter_if_ready();
                end
            end
            OP_LOCAL_REL: begin
                if (holding) begin
                    holding = 1'b0;
                    if (deferred != '0) begin
                        lam_clock   = tick(lam_clock);
                        r.ack_mask  = deferred;
                        r.out_stamp = lam_clock;
                        deferred    = '0;
                    end
                end
            end
            default: begin
                // messages from this node itself are dropped
                if (src != my_id && int'(src) < NODES) begin
                    lam_clock = tick((lam_clock > stamp) ? lam_clock : stamp);
                    if (op == OP_IN_REQ) begin
                        wins = !wanting || stamp < req_stamp ||
                               (stamp == req_stamp && src < my_id);
                        if (!holding && wins) begin
                            lam_clock   = tick(lam_clock);
                            r.ack_mask  = src_bit;
                            r.out_stamp = lam_clock;
                        end else begin
                            deferred |= src_bit;
                        end
                    end else if (wanting && stamp > req_stamp && stamp > entry_stamp) begin
                        acks_held |= src_bit;
                        r.grant = enter_if_ready();
                    end
                end
            end
        endcase
        r.inside_res = holding;
        return r;
    endfunction

    function automatic void flag(input string msg);
        errors++;
        if (errors <= SHOWN) $display("%s", msg);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lam_clock   = '0;
            req_stamp   = '0;
            entry_stamp = '0;
            acks_held   = '0;
            deferred    = '0;
            wanting     = 1'b0;
            holding     = 1'b0;
            my_id       = '0;
            slots       = CFG_W'(1);
            expected_q.delete();
            waiting     = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_addr'(i_cfg_addr))
                    CFG_OWN_ID:     my_id = i_cfg_data;
                    CFG_SLOT_COUNT: slots = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_ev_valid && i_ev_ready) begin
                want = predict_event(t_op'(i_op), i_src, i_stamp);
                grants += int'(want.grant);
                if (want.ack_mask != '0 && t_op'(i_op) == OP_LOCAL_REL) batches++;
                expected_q.insert(expected_q.size(), want);
            end
            if (i_res_valid && i_res_ready) begin
                got = '{ack_mask: i_ack_mask, request_out: i_request_out,
                        out_stamp: i_out_stamp, grant: i_grant, inside_res: i_inside_res};
                if (expected_q.size() == 0) begin
                    flag($sformatf({"%0t: result with nothing expected: mask=%h req=%b",
                                    " stamp=%h grant=%b inside=%b"},
                                   $realtime, got.ack_mask, got.request_out, got.out_stamp,
                                   got.grant, got.inside_res));
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want)
                        flag($sformatf({"%0t: mismatch expected mask=%h req=%b stamp=%h",
                                        " grant=%b inside=%b, got mask=%h req=%b",
                                        " stamp=%h grant=%b inside=%b"},
                                       $realtime, want.ack_mask, want.request_out,
                                       want.out_stamp, want.grant, want.inside_res,
                                       got.ack_mask, got.request_out, got.out_stamp,
                                       got.grant, got.inside_res));
                end
            end
            waiting = expected_q.size();
        end
    end

endmodule

// ===== tb/tb_lamport_k_mutex_node.sv =====
// ----------------------------------------------------------------------------
// tb_lamport_k_mutex_node
// drives request, release and message events into one mutual exclusion node
// under several own-id and slot-count settings; mostly complete entry rounds
// with acknowledges from the other nodes and competing requests around the
// node's own stamp, plus noise bursts, a long result stall, a drain pause and
// a clock saturation tail; the checker module predicts and compares results
// ----------------------------------------------------------------------------
module tb_lamport_k_mutex_node;
    import lkm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES        = 8;
    localparam int PHASES       = 7;
    localparam int PHASE_EVENTS = 135;
    localparam int IDLE_PCT     = 28;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam logic [PORT_SW-1:0] STAMP_MAX = '1;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               ev_valid = 1'b0;
    t_op                ev_op = OP_LOCAL_REQ;
    logic [ID_W-1:0]    ev_src = '0;
    logic [PORT_SW-1:0] ev_stamp = '0;
    logic               ev_ready;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic [MASK_W-1:0]  res_ack_mask;
    logic               res_request_out;
    logic [PORT_SW-1:0] res_out_stamp;
    logic               res_grant;
    logic               res_inside;
    logic               cfg_we = 1'b0;
    t_cfg_addr          cfg_addr = CFG_OWN_ID;
    logic [CFG_W-1:0]   cfg_data = '0;

    int                 sent_count = 0;
    int                 recv_count = 0;
    int                 stall_cycles = 0;
    int                 settings_done = 0;
    bit                 no_idle = 1'b0;
    bit                 hold_out = 1'b0;
    longint unsigned    clk_bound = 0;
    logic [PORT_SW-1:0] own_req_seen = '0;
    logic [ID_W-1:0]    own_id_set = '0;
    logic [CFG_W-1:0]   slots_set = CFG_W'(1);
    int                 chk_errors;
    int                 chk_waiting;
    int                 chk_grants;
    int                 chk_batches;

    always #4 clk = ~clk;

    lamport_k_mutex_node u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (ev_valid),
        .o_ready       (ev_ready),
        .i_op          (ev_op),
        .i_src         (ev_src),
        .i_stamp       (ev_stamp),
        .o_valid       (res_valid),
        .i_ready       (res_ready),
        .o_ack_mask    (res_ack_mask),
        .o_request_out (res_request_out),
        .o_out_stamp   (res_out_stamp),
        .o_grant       (res_grant),
        .o_inside_res  (res_inside),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data)
    );

    lkm_node_checker #(.NODES(NODES)) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_ev_valid    (ev_valid),
        .i_ev_ready    (ev_ready),
        .i_op          (ev_op),
        .i_src         (ev_src),
        .i_stamp       (ev_stamp),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_ack_mask    (res_ack_mask),
        .i_request_out (res_request_out),
        .i_out_stamp   (res_out_stamp),
        .i_grant       (res_grant),
        .i_inside_res  (res_inside),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data),
        .o_errors      (chk_errors),
        .o_waiting     (chk_waiting),
        .o_grants      (chk_grants),
        .o_batches     (chk_batches)
    );

    function automatic logic [PORT_SW-1:0] clamp_stamp(input longint unsigned v);
        return (v > STAMP_MAX) ? STAMP_MAX : v[PORT_SW-1:0];
    endfunction

    // n-th node other than this one, in rotated order
    function automatic logic [ID_W-1:0] other_id(input int n);
        return ID_W'((int'(own_id_set) + 1 + n % (NODES - 1)) % NODES);
    endfunction

    // competing request stamps: near a tie with our request, older, or newer
    function automatic logic [PORT_SW-1:0] pick_req_stamp();
        case ($urandom_range(0, 3))
            0, 1: begin
                if (own_req_seen == '0) return '0;
                return clamp_stamp(longint'(own_req_seen) + $urandom_range(0, 2) - 1);
            end
            2:       return $urandom_range(0, own_req_seen);
            default: return clamp_stamp(clk_bound + $urandom_range(1, 8));
        endcase
    endfunction

    task automatic send_event(input t_op op, input logic [ID_W-1:0] src,
                              input logic [PORT_SW-1:0] stamp);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            ev_valid <= 1'b0;
            @(posedge clk);
        end
        ev_valid <= 1'b1;
        ev_op    <= op;
        ev_src   <= src;
        ev_stamp <= stamp;
        do @(posedge clk); while (!ev_ready);
        sent_count++;
        // upper bound of the node's lamport clock
        if (op == OP_IN_REQ || op == OP_IN_ACK)
            clk_bound = ((stamp > clk_bound) ? stamp : clk_bound) + 2;
        else
            clk_bound = clk_bound + 1;
        if (clk_bound > STAMP_MAX) clk_bound = STAMP_MAX;
    endtask

    task automatic drain();
        ev_valid <= 1'b0;
        do @(posedge clk); while (sent_count != recv_count);
    endtask

    task automatic apply_settings(input logic [ID_W-1:0] id, input logic [CFG_W-1:0] slots);
        drain();
        repeat (3) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_OWN_ID;
        cfg_data <= id;
        @(posedge clk);
        cfg_addr <= CFG_SLOT_COUNT;
        cfg_data <= slots;
        @(posedge clk);
        cfg_we <= 1'b0;
        own_id_set = id;
        slots_set  = slots;
        settings_done++;
    endtask

    // request, acknowledges from others with competing requests, mostly a release
    task automatic run_round();
        int need;
        int n_acks;
        int start;
        need   = NODES - ((slots_set == 0) ? 1 : int'(slots_set));
        n_acks = need + $urandom_range(0, 2) - (($urandom_range(0, 4) == 0) ? 2 : 0);
        if (n_acks < 0) n_acks = 0;
        start  = $urandom_range(0, NODES - 2);
        send_event(OP_LOCAL_REQ, ID_W'($urandom), $urandom);
        for (int i = 0; i < n_acks; i++) begin
            if ($urandom_range(0, 99) < 30)
                send_event(OP_IN_REQ, other_id($urandom_range(0, NODES - 2)), pick_req_stamp());
            send_event(OP_IN_ACK, other_id(start + i),
                       clamp_stamp(clk_bound + 1 + $urandom_range(0, 3)));
        end
        if ($urandom_range(0, 99) < 85)
            send_event(OP_LOCAL_REL, ID_W'($urandom), $urandom);
    endtask

    task automatic run_noise();
        int                 n;
        logic [PORT_SW-1:0] stamp;
        n = $urandom_range(3, 8);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 14) == 0)
                stamp = $urandom;
            else
                stamp = $urandom_range(0, clamp_stamp(clk_bound + 20));
            send_event(t_op'($urandom_range(0, 3)), ID_W'($urandom), stamp);
        end
    endtask

    // result side: random backpressure and one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (res_valid && res_ready) begin
                recv_count <= recv_count + 1;
                if (res_request_out) own_req_seen <= res_out_stamp;
            end
            if (hold_out) begin
                res_ready <= 1'b0;
                hold_out = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                res_ready <= no_idle || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (ev_valid && ev_ready) || (res_valid && res_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("** lamport_k_mutex_node: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [ID_W-1:0]  ids[PHASES];
        logic [CFG_W-1:0] slot_list[PHASES];
        int               phase_start;
        bit               held;
        bit               paused;
        ids       = '{3'd0, 3'd7, 3'd5, 3'd2, ID_W'($urandom), ID_W'($urandom), 3'd6};
        slot_list = '{3'd1, 3'd7, 3'd0, 3'd4, CFG_W'($urandom), CFG_W'($urandom), 3'd3};
        held   = 1'b0;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: node 3, one acknowledge needed
        apply_settings(3'd3, 3'd7);
        send_event(OP_LOCAL_REL, 3'd0, '0);          // release while outside
        send_event(OP_IN_ACK, 3'd1, '0);             // acknowledge while idle
        send_event(OP_IN_REQ, 3'd3, 32'd5);          // message from self
        send_event(OP_IN_REQ, 3'd2, '0);             // idle, answered at once
        send_event(OP_LOCAL_REQ, 3'd7, STAMP_MAX);
        send_event(OP_LOCAL_REQ, 3'd0, '0);          // already requesting
        send_event(OP_IN_REQ, 3'd2, 32'd4);          // tie, lower id wins
        send_event(OP_IN_REQ, 3'd5, 32'd4);          // tie, higher id deferred
        send_event(OP_IN_REQ, 3'd0, 32'd9);          // newer, deferred
        send_event(OP_IN_ACK, 3'd4, 32'd3);          // stale acknowledge
        send_event(OP_IN_ACK, 3'd4, 32'd12);         // enters
        send_event(OP_IN_REQ, 3'd1, '0);             // inside, deferred
        send_event(OP_LOCAL_REQ, 3'd0, '0);          // inside
        send_event(OP_LOCAL_REL, 3'd0, '0);          // batch of deferred acks
        send_event(OP_LOCAL_REL, 3'd0, '0);
        send_event(OP_LOCAL_REQ, 3'd0, '0);
        send_event(OP_IN_ACK, 3'd6, 32'd14);         // older than the request
        send_event(OP_IN_ACK, 3'd7, 32'd17);
        send_event(OP_LOCAL_REL, 3'd5, '0);          // nothing deferred

        for (int p = 0; p < PHASES; p++) begin
            apply_settings(ids[p], slot_list[p]);
            no_idle = (p == 3);
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_EVENTS) begin
                if (p == 1 && !held && sent_count - phase_start >= 40) begin
                    hold_out = 1'b1;
                    held     = 1'b1;
                end
                if (p == 4 && !paused && sent_count - phase_start >= 60) begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 4) == 0)
                    run_noise();
                else
                    run_round();
            end
        end
        no_idle = 1'b0;

        // clock saturation at the very end
        send_event(OP_IN_REQ, other_id(0), STAMP_MAX - 1);
        send_event(OP_IN_ACK, other_id(1), STAMP_MAX);
        send_event(OP_LOCAL_REQ, 3'd0, '0);
        send_event(OP_IN_REQ, 3'd0, STAMP_MAX);
        send_event(OP_IN_REQ, 3'd7, STAMP_MAX);
        send_event(OP_IN_ACK, other_id(2), STAMP_MAX);
        send_event(OP_LOCAL_REL, 3'd0, '0);
        send_event(OP_IN_ACK, other_id(3), STAMP_MAX);

        drain();
        repeat (4) @(posedge clk);
        $display("covered %0d events under %0d register settings", sent_count, settings_done);
        $display("%0d entries granted, %0d deferred acknowledge batches released",
                 chk_grants, chk_batches);
        if (chk_waiting != 0) $display("%0d expected results never arrived", chk_waiting);
        if (chk_errors == 0 && chk_waiting == 0)
            $display("** lamport_k_mutex_node: PASSED **");
        else
            $display("** lamport_k_mutex_node: FAILED **");
        $finish;
    end

endmodule
